// ----- rtl/core/als_pkg.sv -----
// Shared constants, payload types and state encoding for the line stipple dash generator.
package als_pkg;

    localparam int DASH_STEP   = 4;
    localparam int MAX_LENGTH  = 512;
    localparam int MAX_RESULTS = 64;

    localparam int POS_W   = 17;
    localparam int COORD_W = 17;
    localparam int HW_W    = 7;
    localparam int PAT_W   = 32;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int MAG_W   = $clog2(((MAX_LENGTH > DASH_STEP) ? MAX_LENGTH : DASH_STEP) + 1);

    typedef struct packed {
        logic                      vertical;
        logic signed [15:0]        base;
        logic signed [COORD_W-1:0] cross_lo;
        logic signed [COORD_W-1:0] cross_hi;
        logic signed [POS_W-1:0]   len;
        logic [MAG_W-1:0]          len_mag;
        logic [PAT_W-1:0]          pattern;
    } t_cmd;

    typedef struct packed {
        logic                      dash_valid;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic                      last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_back_state;

endpackage

// ----- rtl/core/axis_line_stipple_dash_generator_unit.sv -----
// Stippled line dash generator: line commands in, dash rectangles out.
//
// Input channel: a command (axis, start point, signed length, width, 32-bit
// stipple pattern) is transferred at a clock edge with i_push high and o_full
// low. Output channel: the oldest result sits on the o_ ports while o_empty is
// low and is transferred at an edge with i_pop high and o_empty low.
// Each command yields one result per dash (at most 64), the last one marked
// with o_last; a command without dashes yields one result with o_dash_valid 0.
// With an idle back stage, a zero-length command passes the front register,
// the command queue, the back stage load and the result queue before it shows.
// Each dash is held until the next dash closes or the walk ends, so the first
// dash shows only once the walk has reached the close of the second dash or
// the end of the line.
// Throughput: the back stage walks one step per cycle while the result queue
// has room, so a command occupies it for its whole walk plus load and finish;
// this walk loop sets the sustained rate. A two-entry command queue lets new
// commands be taken while a line is still being walked.
// When the receiver stalls, the two-entry result queue fills and the walk
// pauses; no result is lost. Synchronous reset empties both queues and
// returns the walker to idle.
module axis_line_stipple_dash_generator_unit
    import als_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_func,
    input  logic [15:0]               i_start_x,
    input  logic [15:0]               i_start_y,
    input  logic [10:0]               i_length,
    input  logic [7:0]                i_line_width,
    input  logic [31:0]               i_pattern,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic                      o_dash_valid,
    output logic signed [COORD_W-1:0] o_corner_a_x,
    output logic signed [COORD_W-1:0] o_corner_a_y,
    output logic signed [COORD_W-1:0] o_corner_b_x,
    output logic signed [COORD_W-1:0] o_corner_b_y,
    output logic                      o_last
);

    t_cmd front_cmd;
    logic front_push;
    logic q_full;
    t_cmd q_data;
    logic q_empty;
    logic q_pop;

    als_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_func       (i_func),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_length     (i_length),
        .i_line_width (i_line_width),
        .i_pattern    (i_pattern),
        .o_cmd_push   (front_push),
        .o_cmd        (front_cmd),
        .i_q_full     (q_full)
    );

    als_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    als_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_data),
        .i_cmd_empty  (q_empty),
        .o_cmd_pop    (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_dash_valid (o_dash_valid),
        .o_corner_a_x (o_corner_a_x),
        .o_corner_a_y (o_corner_a_y),
        .o_corner_b_x (o_corner_b_x),
        .o_corner_b_y (o_corner_b_y),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/core/als_front.sv -----
// Front stage: accepts line commands, saturates the length and precomputes the cross-axis corners.
module als_front
    import als_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic         i_func,
    input  logic [15:0]  i_start_x,
    input  logic [15:0]  i_start_y,
    input  logic [10:0]  i_length,
    input  logic [7:0]   i_line_width,
    input  logic [31:0]  i_pattern,
    output logic         o_cmd_push,
    output t_cmd         o_cmd,
    input  logic         i_q_full
);

    localparam logic signed [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);

    logic                      r_valid;
    logic                      n_valid;
    t_cmd                      r_cmd;
    t_cmd                      n_cmd;
    logic                      accept;
    logic                      drain;
    logic signed [POS_W-1:0]   len_ext;
    logic signed [POS_W-1:0]   len_sat;
    logic signed [POS_W-1:0]   len_abs;
    logic [15:0]               cross_sel;
    logic [COORD_W-1:0]        cross_ext;
    logic [COORD_W-1:0]        hw_ext;

    assign o_full     = r_valid && i_q_full;
    assign accept     = i_push && !o_full;
    assign drain      = r_valid && !i_q_full;
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        len_ext = {{(POS_W - 11){i_length[10]}}, i_length};
        if (len_ext > MAX_POS) begin
            len_sat = MAX_POS;
        end else if (len_ext < -MAX_POS) begin
            len_sat = -MAX_POS;
        end else begin
            len_sat = len_ext;
        end
        len_abs   = len_sat[POS_W-1] ? -len_sat : len_sat;
        cross_sel = i_func ? i_start_x : i_start_y;
        cross_ext = {cross_sel[15], cross_sel};
        hw_ext    = {{(COORD_W - HW_W){1'b0}}, i_line_width[7:1]};

        n_cmd.vertical = i_func;
        n_cmd.base     = i_func ? i_start_y : i_start_x;
        n_cmd.cross_lo = cross_ext - hw_ext;
        n_cmd.cross_hi = cross_ext + hw_ext;
        n_cmd.len      = len_sat;
        n_cmd.len_mag  = len_abs[MAG_W-1:0];
        n_cmd.pattern  = i_pattern;

        if (accept) begin
            n_valid = 1'b1;
        end else if (drain) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- rtl/core/als_cmd_queue.sv -----
// Two-entry queue of classified commands between the front and back stages.
module als_cmd_queue
    import als_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/als_back.sv -----
// Back stage: walks a line one step per unstalled cycle, forms and queues dash rectangles.
module als_back
    import als_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic                      i_cmd_empty,
    output logic                      o_cmd_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic                      o_dash_valid,
    output logic signed [COORD_W-1:0] o_corner_a_x,
    output logic signed [COORD_W-1:0] o_corner_a_y,
    output logic signed [COORD_W-1:0] o_corner_b_x,
    output logic signed [COORD_W-1:0] o_corner_b_y,
    output logic                      o_last
);

    localparam logic signed [POS_W-1:0] STEP_POS = POS_W'(DASH_STEP);
    localparam logic [MAG_W-1:0]        STEP_MAG = MAG_W'(DASH_STEP);
    localparam logic [CNT_W-1:0]        CNT_MAX  = CNT_W'(MAX_RESULTS);

    function automatic t_res mk_res(input t_cmd cmd, input logic signed [POS_W-1:0] s_pos,
                                    input logic signed [POS_W-1:0] e_pos, input logic last);
        t_res                      res;
        logic signed [COORD_W-1:0] base_ext;
        logic signed [COORD_W-1:0] along_a;
        logic signed [COORD_W-1:0] along_b;
        base_ext = {cmd.base[15], cmd.base};
        along_a  = base_ext + s_pos;
        along_b  = base_ext + e_pos;
        res.dash_valid = 1'b1;
        res.last       = last;
        if (cmd.vertical) begin
            res.a_x = cmd.cross_lo;
            res.a_y = along_a;
            res.b_x = cmd.cross_hi;
            res.b_y = along_b;
        end else begin
            res.a_x = along_a;
            res.a_y = cmd.cross_lo;
            res.b_x = along_b;
            res.b_y = cmd.cross_hi;
        end
        return res;
    endfunction

    t_back_state             r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic signed [POS_W-1:0] r_cursor, n_cursor;
    logic signed [POS_W-1:0] r_run_start, n_run_start;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_open, n_open;
    logic [MAG_W-1:0]        r_rem, n_rem;
    logic                    r_held_valid, n_held_valid;
    logic signed [POS_W-1:0] r_held_start, n_held_start;
    logic signed [POS_W-1:0] r_held_end, n_held_end;
    logic [CNT_W-1:0]        r_count, n_count;

    t_res                    r_omem [2];
    logic                    r_owr;
    logic                    r_ord;
    logic [1:0]              r_ocnt;
    logic                    out_full;
    logic                    out_pop;
    logic                    push;
    t_res                    push_res;

    logic                    step_done;
    logic signed [POS_W-1:0] step_cursor;
    logic [IDX_W-1:0]        step_idx;
    logic                    step_bit;
    logic                    found;

    assign out_full = (r_ocnt == 2'd2);
    assign o_empty  = (r_ocnt == 2'd0);
    assign out_pop  = i_pop && !o_empty;

    assign o_dash_valid = r_omem[r_ord].dash_valid;
    assign o_corner_a_x = r_omem[r_ord].a_x;
    assign o_corner_a_y = r_omem[r_ord].a_y;
    assign o_corner_b_x = r_omem[r_ord].b_x;
    assign o_corner_b_y = r_omem[r_ord].b_y;
    assign o_last       = r_omem[r_ord].last;

    // One walk step: the final step lands exactly on the end point.
    always_comb begin
        step_done   = (r_rem <= STEP_MAG);
        step_cursor = step_done ? r_cmd.len
                    : (r_cmd.len[POS_W-1] ? r_cursor - STEP_POS : r_cursor + STEP_POS);
        step_idx    = r_idx + IDX_W'(1);
        step_bit    = r_cmd.pattern[step_idx];
        found       = r_open && (!step_bit || step_done);
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cursor     = r_cursor;
        n_run_start  = r_run_start;
        n_idx        = r_idx;
        n_open       = r_open;
        n_rem        = r_rem;
        n_held_valid = r_held_valid;
        n_held_start = r_held_start;
        n_held_end   = r_held_end;
        n_count      = r_count;
        o_cmd_pop    = 1'b0;
        push         = 1'b0;
        push_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop    = 1'b1;
                    n_cmd        = i_cmd;
                    n_cursor     = '0;
                    n_run_start  = '0;
                    n_idx        = '0;
                    n_open       = i_cmd.pattern[0];
                    n_rem        = i_cmd.len_mag;
                    n_held_valid = 1'b0;
                    n_count      = '0;
                    n_state      = (i_cmd.len_mag == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK: begin
                if (!out_full) begin
                    n_cursor = step_cursor;
                    n_idx    = step_idx;
                    n_rem    = r_rem - STEP_MAG;
                    if (r_open) begin
                        if (found) begin
                            n_run_start = step_cursor;
                            n_open      = 1'b0;
                        end
                    end else if (step_bit) begin
                        n_run_start = step_cursor;
                        n_open      = 1'b1;
                    end
                    // The newest dash is held back until it is known whether it is the last.
                    if (found && (r_count < CNT_MAX)) begin
                        if (r_held_valid) begin
                            push     = 1'b1;
                            push_res = mk_res(r_cmd, r_held_start, r_held_end, 1'b0);
                        end
                        n_held_valid = 1'b1;
                        n_held_start = r_run_start;
                        n_held_end   = step_cursor;
                        n_count      = r_count + CNT_W'(1);
                    end
                    if (step_done) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!out_full) begin
                    push = 1'b1;
                    if (r_held_valid) begin
                        push_res = mk_res(r_cmd, r_held_start, r_held_end, 1'b1);
                    end else begin
                        push_res      = '0;
                        push_res.last = 1'b1;
                    end
                    n_held_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_held_valid <= 1'b0;
            r_owr        <= 1'b0;
            r_ord        <= 1'b0;
            r_ocnt       <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_owr        <= push ? ~r_owr : r_owr;
            r_ord        <= out_pop ? ~r_ord : r_ord;
            r_ocnt       <= r_ocnt + {1'b0, push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cursor     <= n_cursor;
        r_run_start  <= n_run_start;
        r_idx        <= n_idx;
        r_open       <= n_open;
        r_rem        <= n_rem;
        r_held_start <= n_held_start;
        r_held_end   <= n_held_end;
        r_count      <= n_count;
        if (push) begin
            r_omem[r_owr] <= push_res;
        end
    end

endmodule

// ----- rtl/core/als_checker.sv -----
// Port-level checks for the dash generator, bound to the top level.
module als_checker
    import als_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_full,
    input logic                      o_empty,
    input logic                      i_pop,
    input logic                      o_dash_valid,
    input logic signed [COORD_W-1:0] o_corner_a_x,
    input logic signed [COORD_W-1:0] o_corner_a_y,
    input logic signed [COORD_W-1:0] o_corner_b_x,
    input logic signed [COORD_W-1:0] o_corner_b_y,
    input logic                      o_last
);

    // Reset leaves both channels empty and ready.
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (o_empty && !o_full))
        else $error("queues not cleared after reset");

    // A result without a dash is always the only, and therefore last, result.
    a_null_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_dash_valid) |-> o_last)
        else $error("empty-line result without last");

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_dash_valid) |-> (o_corner_a_x == '0 && o_corner_a_y == '0
                                         && o_corner_b_x == '0 && o_corner_b_y == '0))
        else $error("empty-line result with nonzero corners");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_last) && $stable(o_dash_valid)
                                  && $stable(o_corner_a_x) && $stable(o_corner_a_y)
                                  && $stable(o_corner_b_x) && $stable(o_corner_b_y)))
        else $error("stalled result changed");

endmodule

bind axis_line_stipple_dash_generator_unit als_checker u_als_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the stippled line dash generator with a scoreboard class.
import als_pkg::*;

typedef struct packed {
    logic               func;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [10:0] len;
    logic [7:0]         width;
    logic [31:0]        pattern;
} t_line_cmd;

class dash_scoreboard;
    t_res dash_queue[$];
    int   n_lines;
    int   n_blank;
    int   n_checked;
    int   n_errors;

    task report(string msg);
        n_errors++;
        if (n_errors <= 40) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Walks the line the same way the block does and queues one rectangle per dash.
    function void note_line(t_line_cmd c);
        t_res       line_dashes[$];
        t_res       r;
        int         len;
        int         dir;
        int         hw;
        int         sx;
        int         sy;
        int         cursor;
        int         run_start;
        int         rem;
        logic [4:0] idx;
        bit         dash_on;
        bit         at_end;
        bit         b;

        len = int'(c.len);
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        if (len < -MAX_LENGTH) len = -MAX_LENGTH;
        dir = (len < 0) ? -1 : 1;
        hw = int'(c.width) >> 1;
        sx = int'(c.start_x);
        sy = int'(c.start_y);
        cursor = 0;
        run_start = 0;
        idx = '0;
        dash_on = c.pattern[0];
        at_end = 1'b0;
        n_lines++;

        while (len != 0 && !at_end) begin
            rem = len - cursor;
            if (rem < 0) rem = -rem;
            if (rem <= DASH_STEP) begin
                cursor = len;
                at_end = 1'b1;
            end else begin
                cursor += dir * DASH_STEP;
            end
            idx = idx + 5'd1;
            b = c.pattern[idx];
            if (dash_on) begin
                // A dash still open at the end point is closed there.
                if (!b || at_end) begin
                    if (line_dashes.size() < MAX_RESULTS) begin
                        r.dash_valid = 1'b1;
                        r.last = 1'b0;
                        if (c.func) begin
                            r.a_x = COORD_W'(sx - hw);
                            r.a_y = COORD_W'(sy + run_start);
                            r.b_x = COORD_W'(sx + hw);
                            r.b_y = COORD_W'(sy + cursor);
                        end else begin
                            r.a_x = COORD_W'(sx + run_start);
                            r.a_y = COORD_W'(sy - hw);
                            r.b_x = COORD_W'(sx + cursor);
                            r.b_y = COORD_W'(sy + hw);
                        end
                        line_dashes.push_back(r);
                    end
                    run_start = cursor;
                    dash_on = 1'b0;
                end
            end else if (b) begin
                run_start = cursor;
                dash_on = 1'b1;
            end
        end

        if (line_dashes.size() == 0) begin
            r = '0;
            r.last = 1'b1;
            line_dashes.push_back(r);
            n_blank++;
        end else begin
            line_dashes[line_dashes.size() - 1].last = 1'b1;
        end
        foreach (line_dashes[k]) dash_queue.push_back(line_dashes[k]);
    endfunction

    function string diff(string name, int got, int want);
        return $sformatf("result %0d field %s: got %0d, expected %0d",
                         n_checked, name, got, want);
    endfunction

    task check_dash(t_res got);
        t_res want;
        if (dash_queue.size() == 0) begin
            report($sformatf("result with nothing expected: v%0d a(%0d,%0d) b(%0d,%0d) last %0d",
                             got.dash_valid, got.a_x, got.a_y, got.b_x, got.b_y, got.last));
            return;
        end
        want = dash_queue.pop_front();
        if (got.dash_valid !== want.dash_valid)
            report(diff("dash_valid", int'(got.dash_valid), int'(want.dash_valid)));
        if (got.a_x !== want.a_x) report(diff("corner_a_x", int'(got.a_x), int'(want.a_x)));
        if (got.a_y !== want.a_y) report(diff("corner_a_y", int'(got.a_y), int'(want.a_y)));
        if (got.b_x !== want.b_x) report(diff("corner_b_x", int'(got.b_x), int'(want.b_x)));
        if (got.b_y !== want.b_y) report(diff("corner_b_y", int'(got.b_y), int'(want.b_y)));
        if (got.last !== want.last) report(diff("last", int'(got.last), int'(want.last)));
        n_checked++;
    endtask
endclass

module testbench;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_push;
    logic                      o_full;
    logic                      i_func;
    logic [15:0]               i_start_x;
    logic [15:0]               i_start_y;
    logic [10:0]               i_length;
    logic [7:0]                i_line_width;
    logic [31:0]               i_pattern;
    logic                      o_empty;
    logic                      i_pop;
    logic                      o_dash_valid;
    logic signed [COORD_W-1:0] o_corner_a_x;
    logic signed [COORD_W-1:0] o_corner_a_y;
    logic signed [COORD_W-1:0] o_corner_b_x;
    logic signed [COORD_W-1:0] o_corner_b_y;
    logic                      o_last;

    dash_scoreboard sb = new();

    axis_line_stipple_dash_generator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_func       (i_func),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_length     (i_length),
        .i_line_width (i_line_width),
        .i_pattern    (i_pattern),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_dash_valid (o_dash_valid),
        .o_corner_a_x (o_corner_a_x),
        .o_corner_a_y (o_corner_a_y),
        .o_corner_b_x (o_corner_b_x),
        .o_corner_b_y (o_corner_b_y),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_line_cmd make_line(bit func, int x, int y, int len, int w,
                                            logic [31:0] pat);
        t_line_cmd c;
        c.func = func;
        c.start_x = 16'(x);
        c.start_y = 16'(y);
        c.len = 11'(len);
        c.width = 8'(w);
        c.pattern = pat;
        return c;
    endfunction

    // Mostly short lines keep the run quick; a share uses the full 11-bit length field.
    function automatic t_line_cmd random_line();
        t_line_cmd c;
        int        l;
        int        sel;
        c.func = 1'($urandom_range(0, 1));
        c.start_x = 16'($urandom);
        c.start_y = 16'($urandom);
        if ($urandom_range(0, 7) == 0) c.start_x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(0, 7) == 0) c.start_y = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        c.width = 8'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            l = $urandom_range(0, 48);
        end else if (sel < 8) begin
            l = $urandom_range(0, 2047);
        end else begin
            l = $urandom_range(500, 1024);
        end
        if (sel < 6 || sel >= 8) begin
            if ($urandom_range(0, 1)) l = -l;
        end
        c.len = 11'(l);
        case ($urandom_range(0, 3))
            0: c.pattern = $urandom;
            1: c.pattern = $urandom & $urandom;
            2: c.pattern = $urandom | $urandom;
            default: c.pattern = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
        return c;
    endfunction

    // Leaves i_push as it is when no gap is drawn, so back-to-back
    // transfers keep i_push high.
    task automatic send_line(t_line_cmd c, int item_no);
        int gap;
        gap = ((item_no / 20) % 4 == 1) ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_func <= c.func;
        i_start_x <= c.start_x;
        i_start_y <= c.start_y;
        i_length <= c.len;
        i_line_width <= c.width;
        i_pattern <= c.pattern;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_line(c);
    endtask

    task automatic drain_lines();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.dash_queue.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_line_cmd directed[$];
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_func = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_length = '0;
        i_line_width = '0;
        i_pattern = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_line(0, 0, 0, 0, 8, 32'hFFFF_FFFF));
        directed.push_back(make_line(1, 100, -100, 0, 0, 32'h0));
        directed.push_back(make_line(0, 10, 20, 100, 6, 32'h0));
        directed.push_back(make_line(0, 32767, 32767, 512, 255, 32'hFFFF_FFFF));
        directed.push_back(make_line(1, -32768, -32768, -512, 255, 32'hFFFF_FFFF));
        directed.push_back(make_line(0, -32768, 32767, 1023, 1, 32'hF0F0_F0F0));
        directed.push_back(make_line(1, 32767, -32768, -1024, 254, 32'h0F0F_0F0F));
        directed.push_back(make_line(0, 0, 0, 512, 4, 32'h5555_5555));
        directed.push_back(make_line(1, 5, 5, -512, 3, 32'hAAAA_AAAA));
        directed.push_back(make_line(0, 7, -7, 1, 2, 32'h1));
        directed.push_back(make_line(1, -7, 7, -3, 9, 32'h1));
        directed.push_back(make_line(0, 300, 300, 5, 16, 32'h3));
        directed.push_back(make_line(1, -300, 300, -7, 17, 32'h2));
        directed.push_back(make_line(0, 1, 1, 4, 0, 32'h1));
        directed.push_back(make_line(1, 2, 2, 200, 30, 32'h8000_0000));
        directed.push_back(make_line(0, 3, 3, -200, 31, 32'hFFFF_FFFE));
        directed.push_back(make_line(1, -40, 40, 130, 100, 32'h8000_0001));
        directed.push_back(make_line(0, 40, -40, 129, 101, 32'h7FFF_FFFF));
        directed.push_back(make_line(1, 0, 0, 3, 5, 32'h0));
        directed.push_back(make_line(1, 1234, -4321, 60, 0, 32'hDEAD_BEEF));
        directed.push_back(make_line(0, -1, -1, -1, 255, 32'hFFFF_FFFF));
        foreach (directed[k]) send_line(directed[k], k);

        // Let the block empty out completely before the random part.
        drain_lines();

        for (int n = 0; n < 210; n++) begin
            if (n == 70 || n == 140) drain_lines();
            send_line(random_line(), n);
        end
        drain_lines();
        repeat (140) @(posedge i_clk);

        if (sb.dash_queue.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.dash_queue.size()));
        $display("Sent %0d line commands on both axes (%0d without any dash), checked %0d results;",
                 sb.n_lines, sb.n_blank, sb.n_checked);
        $display("lengths spanned the saturated extremes and both channels stalled at random.");
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        t_res got;
        int   stall;
        int   taken;
        taken = 0;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = ((taken / 24) % 4 == 3) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            got.dash_valid = o_dash_valid;
            got.a_x = o_corner_a_x;
            got.a_y = o_corner_a_y;
            got.b_x = o_corner_b_x;
            got.b_y = o_corner_b_y;
            got.last = o_last;
            taken++;
            sb.check_dash(got);
        end
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
